// ===== hw/rtl/daisy_chain_command_frame_builder_unit_macros.svh =====
// Assertion macros shared by the frame builder.
`ifndef DAISY_CHAIN_COMMAND_FRAME_BUILDER_UNIT_MACROS_SVH
`define DAISY_CHAIN_COMMAND_FRAME_BUILDER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk and quiet during reset.
`define DCCFB_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame builder check failed");

// Next-cycle implication, sampled on clk and quiet during reset.
`define DCCFB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame builder check failed");

`endif

// ===== hw/rtl/dccfb_pkg.sv =====
`timescale 1ns / 1ps

package dccfb_pkg;

    localparam int unsigned IN_DATA_W = 64;
    localparam int unsigned HDR_BYTES = 5;

    localparam logic [2:0] KIND_SINGLE_RD = 3'd0;
    localparam logic [2:0] KIND_SINGLE_WR = 3'd1;
    localparam logic [2:0] KIND_BCAST_WR  = 3'd5;

    localparam logic [7:0]  INIT_BASE = 8'h80;
    localparam logic [7:0]  READ_MAX  = 8'd128;
    localparam logic [15:0] CRC_SEED  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'hA001;

    typedef struct packed {
        logic [2:0]           kind;
        logic [7:0]           device_id;
        logic [15:0]          reg_addr;
        logic [IN_DATA_W-1:0] write_data;
        logic [7:0]           byte_count;
    } req_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } rsp_t;

    typedef struct packed {
        logic clear;
        logic update;
    } crc_ctl_t;

endpackage

// ===== hw/rtl/daisy_chain_command_frame_builder_unit.sv =====
// A taken request loads the header shifter; frame words reach out_data through the
// output register. A frame has 6 to 14 words and moves on while out_ready is high or
// the output register is empty. The next request is taken only from idle, once the
// last word of the frame has entered the output register.
// A rejected request is consumed in idle and yields no word.
// Reset (rst_n low, asynchronous) empties the output register and returns to idle.
`timescale 1ns / 1ps

`include "daisy_chain_command_frame_builder_unit_macros.svh"

module daisy_chain_command_frame_builder_unit
#(
    parameter int unsigned MAX_WRITE_BYTES = 8
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  dccfb_pkg::req_t in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output dccfb_pkg::rsp_t out_data
);

    localparam int unsigned DW  = MAX_WRITE_BYTES * 8;
    localparam int unsigned HW  = dccfb_pkg::HDR_BYTES * 8;
    localparam int unsigned CW  = $clog2(MAX_WRITE_BYTES + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_HDR,
        S_DATA,
        S_CRC_LO,
        S_CRC_HI
    } state_t;

    state_t          state_reg, state_next;
    logic [HW-1:0]   hdr_reg, hdr_next;
    logic [2:0]      hdr_left_reg, hdr_left_next;
    logic [DW-1:0]   data_reg, data_next;
    logic [CW-1:0]   data_left_reg, data_left_next;
    logic            wr_reg, wr_next;
    logic            ovalid_reg, ovalid_next;
    dccfb_pkg::rsp_t out_reg, out_next;

    dccfb_pkg::crc_ctl_t crc_ctl;
    logic [7:0]          crc_byte;
    logic [15:0]         crc;

    logic       accept;
    logic       adv;
    logic       is_write;
    logic       req_ok;
    logic [7:0] cnt_m1;
    logic [7:0] init_byte;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign adv       = !ovalid_reg || out_ready;
    assign is_write  = in_data.kind[0];
    assign cnt_m1    = in_data.byte_count - 8'd1;
    assign init_byte = dccfb_pkg::INIT_BASE | {1'b0, in_data.kind, 4'h0}
                       | (is_write ? cnt_m1 : 8'h00);

    always_comb
    begin
        req_ok = (in_data.kind <= dccfb_pkg::KIND_BCAST_WR) && (in_data.byte_count != 8'd0);
        if (is_write && (in_data.byte_count > 8'(MAX_WRITE_BYTES)))
            req_ok = 1'b0;
        if (!is_write && (in_data.byte_count > dccfb_pkg::READ_MAX))
            req_ok = 1'b0;
    end

    always_comb
    begin
        state_next     = state_reg;
        hdr_next       = hdr_reg;
        hdr_left_next  = hdr_left_reg;
        data_next      = data_reg;
        data_left_next = data_left_reg;
        wr_next        = wr_reg;
        ovalid_next    = ovalid_reg;
        out_next       = out_reg;
        crc_ctl        = '0;
        crc_byte       = hdr_reg[HW-1 -: 8];

        case (state_reg)
            S_IDLE:
            begin
                if (adv)
                    ovalid_next = 1'b0;
                if (accept && req_ok)
                begin
                    crc_ctl.clear = 1'b1;
                    wr_next       = is_write;
                    state_next    = S_HDR;
                    // Header words are left-justified in the order they go out.
                    case (in_data.kind)
                        dccfb_pkg::KIND_SINGLE_RD:
                        begin
                            hdr_next = {init_byte, in_data.device_id, in_data.reg_addr, cnt_m1};
                            hdr_left_next = 3'd5;
                        end
                        dccfb_pkg::KIND_SINGLE_WR:
                        begin
                            hdr_next = {init_byte, in_data.device_id, in_data.reg_addr, 8'h00};
                            hdr_left_next = 3'd4;
                        end
                        default:
                        begin
                            if (is_write)
                            begin
                                hdr_next      = {init_byte, in_data.reg_addr, 16'h0000};
                                hdr_left_next = 3'd3;
                            end
                            else
                            begin
                                hdr_next      = {init_byte, in_data.reg_addr, cnt_m1, 8'h00};
                                hdr_left_next = 3'd4;
                            end
                        end
                    endcase
                    // Align the highest used data word to the top of the shifter.
                    for (int k = 1; k <= int'(MAX_WRITE_BYTES); k++)
                    begin
                        if (in_data.byte_count == 8'(k))
                            data_next = in_data.write_data[DW-1:0] << ((int'(MAX_WRITE_BYTES) - k) * 8);
                    end
                    data_left_next = in_data.byte_count[CW-1:0];
                end
            end
            S_HDR:
            begin
                if (adv)
                begin
                    crc_ctl.update = 1'b1;
                    ovalid_next    = 1'b1;
                    out_next       = '{frame_byte: hdr_reg[HW-1 -: 8], last_byte: 1'b0};
                    hdr_next       = hdr_reg << 8;
                    hdr_left_next  = hdr_left_reg - 3'd1;
                    if (hdr_left_reg == 3'd1)
                        state_next = wr_reg ? S_DATA : S_CRC_LO;
                end
            end
            S_DATA:
            begin
                crc_byte = data_reg[DW-1 -: 8];
                if (adv)
                begin
                    crc_ctl.update = 1'b1;
                    ovalid_next    = 1'b1;
                    out_next       = '{frame_byte: data_reg[DW-1 -: 8], last_byte: 1'b0};
                    data_next      = data_reg << 8;
                    data_left_next = data_left_reg - CW'(1);
                    if (data_left_reg == CW'(1))
                        state_next = S_CRC_LO;
                end
            end
            S_CRC_LO:
            begin
                if (adv)
                begin
                    ovalid_next = 1'b1;
                    out_next    = '{frame_byte: crc[7:0], last_byte: 1'b0};
                    state_next  = S_CRC_HI;
                end
            end
            S_CRC_HI:
            begin
                if (adv)
                begin
                    ovalid_next = 1'b1;
                    out_next    = '{frame_byte: crc[15:8], last_byte: 1'b1};
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ovalid_reg    <= 1'b0;
            hdr_reg       <= '0;
            hdr_left_reg  <= '0;
            data_reg      <= '0;
            data_left_reg <= '0;
            wr_reg        <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            ovalid_reg    <= ovalid_next;
            hdr_reg       <= hdr_next;
            hdr_left_reg  <= hdr_left_next;
            data_reg      <= data_next;
            data_left_reg <= data_left_next;
            wr_reg        <= wr_next;
            out_reg       <= out_next;
        end
    end

    dccfb_crc16 u_crc
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (crc_ctl),
        .data  (crc_byte),
        .crc   (crc)
    );

    assign out_valid = ovalid_reg;
    assign out_data  = out_reg;

    // A fresh frame starts from the seed value.
    `DCCFB_ASSERT_NEXT(a_crc_seeded, accept && req_ok, crc == dccfb_pkg::CRC_SEED)
    // The closing word cannot be pending before the high CRC word is sent.
    `DCCFB_ASSERT_NOW(a_last_after_crc, state_reg == S_CRC_HI, !(ovalid_reg && out_reg.last_byte))
    // The data shifter is never entered with nothing left to send.
    `DCCFB_ASSERT_NOW(a_data_left, state_reg == S_DATA, data_left_reg != '0)

endmodule

// ===== hw/rtl/dccfb_crc16.sv =====
`timescale 1ns / 1ps

module dccfb_crc16
(
    input  logic                clk,
    input  logic                rst_n,
    input  dccfb_pkg::crc_ctl_t ctl,
    input  logic [7:0]          data,
    output logic [15:0]         crc
);

    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic [15:0] step;

    // Reflected CRC-16, one byte folded in per update.
    always_comb
    begin
        step = crc_reg ^ {8'h00, data};
        for (int i = 0; i < 8; i++)
        begin
            if (step[0])
                step = (step >> 1) ^ dccfb_pkg::CRC_POLY;
            else
                step = step >> 1;
        end
        crc_next = crc_reg;
        if (ctl.clear)
            crc_next = dccfb_pkg::CRC_SEED;
        else if (ctl.update)
            crc_next = step;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            crc_reg <= dccfb_pkg::CRC_SEED;
        else
            crc_reg <= crc_next;
    end

    assign crc = crc_reg;

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;

    // Frame kinds the package leaves unnamed.
    localparam logic [2:0] KIND_STACK_RD  = 3'd2;
    localparam logic [2:0] KIND_STACK_WR  = 3'd3;
    localparam logic [2:0] KIND_BCAST_RD  = 3'd4;
    localparam logic [2:0] KIND_UNUSED_LO = 3'd6;
    localparam logic [2:0] KIND_UNUSED_HI = 3'd7;

    localparam int unsigned MAX_WRITE_BYTES = 8;
    localparam int unsigned CYCLE_LIMIT     = 200000;
    localparam int unsigned MAX_REPORTS     = 10;

    logic clk    = 1'b0;
    logic rst_n  = 1'b0;
    logic in_valid  = 1'b0;
    logic in_ready;
    dccfb_pkg::req_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    dccfb_pkg::rsp_t out_data;

    dccfb_pkg::rsp_t frame_words_due[$];

    int unsigned sender_idle_pct    = 0;
    int unsigned receiver_stall_pct = 0;
    int unsigned cycle_count        = 0;
    int unsigned mismatch_count     = 0;
    int unsigned requests_taken     = 0;
    int unsigned requests_rejected  = 0;
    int unsigned words_checked      = 0;
    int unsigned drain_pauses       = 0;

    daisy_chain_command_frame_builder_unit #(
        .MAX_WRITE_BYTES(MAX_WRITE_BYTES)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words still due",
                     cycle_count, frame_words_due.size());
            $display("daisy_chain_command_frame_builder_unit: mismatch");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    function automatic logic [15:0] crc16_modbus_step(input logic [15:0] crc,
                                                      input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
                c = (c >> 1) ^ dccfb_pkg::CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    // Appends the words of the frame a request should produce; returns 0 for
    // a request the block must drop.
    function automatic bit predict_frame(input dccfb_pkg::req_t r);
        logic [7:0]      frame[$];
        logic [15:0]     crc;
        logic            is_write;
        int unsigned     cnt;
        dccfb_pkg::rsp_t w;
        is_write = r.kind[0];
        cnt      = r.byte_count;
        if (r.kind > dccfb_pkg::KIND_BCAST_WR || cnt == 0)
            return 1'b0;
        if (is_write && cnt > MAX_WRITE_BYTES)
            return 1'b0;
        if (!is_write && cnt > dccfb_pkg::READ_MAX)
            return 1'b0;
        frame.push_back(dccfb_pkg::INIT_BASE | {1'b0, r.kind, 4'h0}
                        | (is_write ? 8'(cnt - 1) : 8'h00));
        if (r.kind <= dccfb_pkg::KIND_SINGLE_WR)
            frame.push_back(r.device_id);
        frame.push_back(r.reg_addr[15:8]);
        frame.push_back(r.reg_addr[7:0]);
        if (is_write)
        begin
            for (int i = cnt; i > 0; i--)
                frame.push_back(r.write_data[(i - 1) * 8 +: 8]);
        end
        else
        begin
            frame.push_back(8'(cnt - 1));
        end
        crc = dccfb_pkg::CRC_SEED;
        foreach (frame[i])
            crc = crc16_modbus_step(crc, frame[i]);
        frame.push_back(crc[7:0]);
        frame.push_back(crc[15:8]);
        foreach (frame[i])
        begin
            w.frame_byte = frame[i];
            w.last_byte  = (i == frame.size() - 1);
            frame_words_due.push_back(w);
        end
        return 1'b1;
    endfunction

    function automatic dccfb_pkg::req_t make_request(input logic [2:0] kind,
                                                     input logic [7:0] dev,
                                                     input logic [15:0] addr,
                                                     input logic [63:0] data,
                                                     input logic [7:0] cnt);
        dccfb_pkg::req_t r;
        r.kind       = kind;
        r.device_id  = dev;
        r.reg_addr   = addr;
        r.write_data = data;
        r.byte_count = cnt;
        return r;
    endfunction

    function automatic dccfb_pkg::req_t random_request();
        dccfb_pkg::req_t r;
        int unsigned     roll;
        roll         = $urandom_range(99);
        r.kind       = 3'($urandom_range(dccfb_pkg::KIND_BCAST_WR));
        r.device_id  = 8'($urandom);
        r.reg_addr   = 16'($urandom);
        r.write_data = {$urandom, $urandom};
        if (roll < 85)
        begin
            if (r.kind[0])
                r.byte_count = 8'($urandom_range(MAX_WRITE_BYTES, 1));
            else if ($urandom_range(3) == 0)
                r.byte_count = $urandom_range(1) ? dccfb_pkg::READ_MAX : 8'd1;
            else
                r.byte_count = 8'($urandom_range(dccfb_pkg::READ_MAX, 1));
        end
        else if (roll < 90)
        begin
            r.kind       = $urandom_range(1) ? KIND_UNUSED_HI : KIND_UNUSED_LO;
            r.byte_count = 8'($urandom);
        end
        else if (roll < 95)
        begin
            r.byte_count = 8'd0;
        end
        else
        begin
            r.byte_count = r.kind[0] ? 8'($urandom_range(255, MAX_WRITE_BYTES + 1))
                                     : 8'($urandom_range(255, dccfb_pkg::READ_MAX + 1));
        end
        return r;
    endfunction

    // Called just after a rising edge. Valid is only lowered when a gap is
    // actually inserted, so back-to-back requests keep it high.
    task automatic send_request(input dccfb_pkg::req_t r, output bit framed);
        if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
        end
        in_valid <= 1'b1;
        in_data  <= r;
        do @(posedge clk); while (!in_ready);
        framed = predict_frame(r);
        requests_taken++;
        if (!framed)
            requests_rejected++;
    endtask

    task automatic send_list(input dccfb_pkg::req_t reqs[$]);
        bit framed;
        foreach (reqs[i])
            send_request(reqs[i], framed);
    endtask

    // Holds the sender off until every frame word has been delivered.
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (frame_words_due.size() != 0);
        repeat (4) @(posedge clk);
        drain_pauses++;
    endtask

    always @(posedge clk)
    begin
        dccfb_pkg::rsp_t want;
        if (rst_n && out_valid && out_ready)
        begin
            words_checked++;
            if (frame_words_due.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected word: byte %02h last %0b",
                             out_data.frame_byte, out_data.last_byte);
            end
            else
            begin
                want = frame_words_due.pop_front();
                if (out_data.frame_byte !== want.frame_byte
                    || out_data.last_byte !== want.last_byte)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("word %0d: expected byte %02h last %0b, got byte %02h last %0b",
                                 words_checked, want.frame_byte, want.last_byte,
                                 out_data.frame_byte, out_data.last_byte);
                end
            end
        end
    end

    task automatic test_frame_kinds();
        dccfb_pkg::req_t reqs[$];
        reqs.push_back(make_request(dccfb_pkg::KIND_SINGLE_RD, 8'h01, 16'h0102, 64'h0, 8'd1));
        reqs.push_back(make_request(dccfb_pkg::KIND_SINGLE_WR, 8'h02, 16'h0304, 64'hA5, 8'd1));
        reqs.push_back(make_request(KIND_STACK_RD,  8'h03, 16'h0506, 64'h0, 8'd1));
        reqs.push_back(make_request(KIND_STACK_WR,  8'h04, 16'h0708, 64'h5A, 8'd1));
        reqs.push_back(make_request(KIND_BCAST_RD,  8'h05, 16'h090A, 64'h0, 8'd1));
        reqs.push_back(make_request(dccfb_pkg::KIND_BCAST_WR, 8'h06, 16'h0B0C, 64'h3C, 8'd1));
        send_list(reqs);
    endtask

    task automatic test_field_extremes();
        dccfb_pkg::req_t reqs[$];
        reqs.push_back(make_request(dccfb_pkg::KIND_SINGLE_WR, 8'hFF, 16'hFFFF, '1, 8'd8));
        reqs.push_back(make_request(dccfb_pkg::KIND_SINGLE_WR, 8'h00, 16'h0000, 64'h0, 8'd8));
        reqs.push_back(make_request(KIND_STACK_WR, 8'h00, 16'h0000,
                                    64'h0123_4567_89AB_CDEF, 8'd8));
        // Payload bytes above the count must not leak into the frame.
        reqs.push_back(make_request(dccfb_pkg::KIND_BCAST_WR, 8'h7E, 16'h8001,
                                    64'hFFFF_FFFF_FF12_3456, 8'd3));
        reqs.push_back(make_request(dccfb_pkg::KIND_SINGLE_RD, 8'h00, 16'h0000, '1,
                                    dccfb_pkg::READ_MAX));
        reqs.push_back(make_request(KIND_BCAST_RD, 8'hFF, 16'hFFFF, 64'h0,
                                    dccfb_pkg::READ_MAX));
        reqs.push_back(make_request(KIND_STACK_RD, 8'h80, 16'h8000, 64'h0, 8'd64));
        send_list(reqs);
    endtask

    task automatic test_rejected_requests();
        dccfb_pkg::req_t reqs[$];
        reqs.push_back(make_request(KIND_UNUSED_LO, 8'h11, 16'h1234, '1, 8'd1));
        reqs.push_back(make_request(KIND_UNUSED_HI, 8'h22, 16'h4321, '1, 8'd4));
        reqs.push_back(make_request(dccfb_pkg::KIND_SINGLE_WR, 8'h33, 16'h1111, '1, 8'd0));
        reqs.push_back(make_request(KIND_STACK_WR, 8'h44, 16'h2222, '1, 8'(MAX_WRITE_BYTES + 1)));
        reqs.push_back(make_request(dccfb_pkg::KIND_BCAST_WR, 8'h55, 16'h3333, '1, 8'd255));
        reqs.push_back(make_request(dccfb_pkg::KIND_SINGLE_RD, 8'h66, 16'h4444, 64'h0, 8'd0));
        reqs.push_back(make_request(KIND_STACK_RD, 8'h77, 16'h5555, 64'h0,
                                    8'(dccfb_pkg::READ_MAX + 1)));
        reqs.push_back(make_request(KIND_BCAST_RD, 8'h88, 16'h6666, 64'h0, 8'd255));
        // A good frame right behind the rejects shows nothing was left half done.
        reqs.push_back(make_request(dccfb_pkg::KIND_SINGLE_RD, 8'h99, 16'h7777, 64'h0, 8'd2));
        send_list(reqs);
    endtask

    task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct,
                                       input int unsigned frames);
        int unsigned framed_count;
        bit          framed;
        framed_count       = 0;
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        while (framed_count < frames)
        begin
            send_request(random_request(), framed);
            if (framed)
                framed_count++;
            if ($urandom_range(24) == 0)
                wait_for_drain();
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_frame_kinds();
        test_field_extremes();
        test_rejected_requests();
        wait_for_drain();

        test_random_traffic(0, 0, 24);
        test_random_traffic(55, 0, 24);
        wait_for_drain();
        test_random_traffic(0, 55, 24);
        test_random_traffic(8, 8, 24);

        in_valid <= 1'b0;
        do @(posedge clk); while (frame_words_due.size() != 0);
        repeat (20) @(posedge clk);
        if (frame_words_due.size() != 0)
            mismatch_count++;

        $display("%0d requests taken (%0d dropped), %0d frame words checked, %0d drain pauses",
                 requests_taken, requests_rejected, words_checked, drain_pauses);
        $display("covered all six frame kinds, count limits, rejects and four idle mixes");
        if (mismatch_count == 0)
            $display("daisy_chain_command_frame_builder_unit: match");
        else
            $display("daisy_chain_command_frame_builder_unit: mismatch");
        $finish;
    end

endmodule

// ===== daisy_chain_command_frame_builder_unit.f =====
+incdir+hw/rtl
hw/rtl/dccfb_pkg.sv
hw/rtl/dccfb_crc16.sv
hw/rtl/daisy_chain_command_frame_builder_unit.sv
bench/tb.sv
